>>> rtl/msa_pkg.sv
// Package for the mutation spread adapter: verdict codes, register indexes,
// fixed-point constants and reset values. No dependencies.
package msa_pkg;

  // Fixed-point layout: spread and factor are unsigned Q8.24.
  localparam int unsigned FracBits = 24;
  localparam int unsigned DataW = 32;
  localparam int unsigned SerialSteps = 32;
  localparam int unsigned StepCntW = $clog2(SerialSteps);

  // Reset values of the registers and of the spread (0.1 rounded to nearest).
  localparam logic [6:0] WindowLengthReset = 7'd10;
  localparam logic [6:0] SuccessTargetReset = 7'd2;
  localparam logic [DataW-1:0] StepFactorReset = 32'd16777216;
  localparam logic [DataW-1:0] SpreadReset = 32'd1677722;

  typedef enum logic [1:0] {
    CFG_WINDOW_LENGTH  = 2'd0,
    CFG_SUCCESS_TARGET = 2'd1,
    CFG_STEP_FACTOR    = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    VERDICT_FILLING   = 2'd0,
    VERDICT_DIVIDED   = 2'd1,
    VERDICT_UNCHANGED = 2'd2,
    VERDICT_MULTIPLIED = 2'd3
  } verdict_e;

endpackage

>>> rtl/msa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the success window of the mutation spread adapter; no dependencies.
module msa_ram #(
  parameter int Width = 1,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read and a write at the same address in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mutation_spread_adapter.sv
// Mutation spread adapter: success-rule step-size control with a bit-serial
// multiply and divide unit. Depends on msa_pkg and msa_ram.
//
// Usage: one input transfer per generation carries best_fitness_i (signed
// Q16.16, lower is better). Each input transfer produces exactly one output
// transfer with the updated spread (unsigned Q8.24), a verdict and the
// success flag. Both channels use valid/ready; the configuration port is a
// plain write port (cfg_we_i, cfg_index_i, cfg_data_i) and must only be
// written while no item is in flight.
// Flow: an item whose verdict is "filling" or "unchanged", or whose
// division saturates, passes from S_LOOK straight to S_DONE. A multiply or
// an unsaturated divide runs one bit per cycle through a 33-bit adder or
// subtractor, 32 steps, before reaching S_DONE. From S_DONE the result
// moves into the output register once it is free, which raises out_valid_o.
// The block works on one item at a time: the next input transfer is taken
// once the previous result has been moved into the output register, so a
// new item may enter while that result still waits.
// When the receiver stalls, the finished result holds in the serial unit
// until the output register frees and input stays blocked meanwhile.
// Reset (rst_ni low) restores the register defaults, empties the success
// window and sets the spread to 0.1; the window RAM itself is not cleared,
// since only entries written since reset are ever read.
module mutation_spread_adapter #(
  parameter int MAX_WINDOW = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] best_fitness_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        spread_o,
  output logic [1:0]         verdict_o,
  output logic               improved_o,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // Widths that follow from the window depth.
  localparam int CntW = $clog2(MAX_WINDOW + 1);
  localparam int PtrW = $clog2(MAX_WINDOW);
  localparam int LenW = (CntW > 7) ? CntW : 7;
  localparam int AddW = CntW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [6:0]  win_len_q;
  logic [6:0]  target_q;
  logic [31:0] factor_q;

  // Adapter state.
  logic signed [31:0] best_q, best_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [CntW-1:0]    sum_q, sum_d;
  logic [PtrW-1:0]    head_q, head_d;
  logic [31:0]        spread_q, spread_d;
  logic               imp_q, imp_d;
  msa_pkg::verdict_e  verdict_q, verdict_d;

  // Serial unit: work_q holds the partial product, or the remainder in the
  // upper half and the dividend/quotient bits in the lower half.
  logic [63:0]                    work_q, work_d;
  logic [31:0]                    mplier_q, mplier_d;
  logic [msa_pkg::StepCntW-1:0]   cnt_q, cnt_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_spread_q;
  logic [1:0]  out_verdict_q;
  logic        out_imp_q;
  logic        out_load;

  logic accept;
  logic imp_now;

  // Window RAM signals.
  logic [AddW-1:0] head_ext, fill_ext, raddr_wide;
  logic [PtrW-1:0] raddr;
  logic            oldest_ram;

  // Decision arithmetic.
  logic [LenW-1:0] wl_ext, len_ext, n_ext, sum_ext, tgt_ext;
  logic            oldest;

  // Serial step arithmetic.
  logic [32:0] mul_sum;
  logic [32:0] div_trial;
  logic        div_ge;
  logic [32:0] div_diff;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // An empty window always counts as a success.
  assign imp_now = (fill_q == '0) || (best_fitness_i < best_q);

  // The oldest bit of the window after the push sits fill_q slots behind the
  // slot that the new bit takes.
  assign head_ext   = AddW'(head_q);
  assign fill_ext   = AddW'(fill_q);
  assign raddr_wide = (head_ext >= fill_ext) ? (head_ext - fill_ext)
                                             : (head_ext + AddW'(MAX_WINDOW) - fill_ext);
  assign raddr      = raddr_wide[PtrW-1:0];

  msa_ram #(
    .Width (1),
    .Depth (MAX_WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (head_q),
    .wdata_i (imp_now),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (oldest_ram)
  );

  // Effective window length: zero counts as one, the depth caps it.
  assign wl_ext  = LenW'(win_len_q);
  assign len_ext = (wl_ext == '0) ? LenW'(1)
                 : (wl_ext > LenW'(MAX_WINDOW)) ? LenW'(MAX_WINDOW) : wl_ext;
  assign n_ext   = LenW'(fill_q) + LenW'(1);
  assign sum_ext = LenW'(sum_q) + LenW'(imp_q);
  assign tgt_ext = LenW'(target_q);
  // With a single bit in the window, the oldest bit is the one just pushed.
  assign oldest  = (fill_q == '0) ? imp_q : oldest_ram;

  // Multiply step: add the multiplicand under the next multiplier bit, then
  // shift the product right by one.
  assign mul_sum = {1'b0, work_q[63:32]} + (mplier_q[0] ? {1'b0, spread_q} : 33'd0);

  // Restoring divide step: bring down one dividend bit and subtract the factor
  // when it fits. The remainder stays below the factor, so 33 bits suffice.
  assign div_trial = {work_q[63:32], work_q[31]};
  assign div_ge    = div_trial >= {1'b0, factor_q};
  assign div_diff  = div_trial - {1'b0, factor_q};

  always_comb begin
    state_d   = state_q;
    best_d    = best_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    head_d    = head_q;
    spread_d  = spread_q;
    imp_d     = imp_q;
    verdict_d = verdict_q;
    work_d    = work_q;
    mplier_d  = mplier_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          imp_d  = imp_now;
          if (imp_now) begin
            best_d = best_fitness_i;
          end
          head_d  = (head_q == PtrW'(MAX_WINDOW - 1)) ? '0 : head_q + PtrW'(1);
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        cnt_d = '0;
        if (n_ext >= len_ext) begin
          // Window full: drop the oldest bit and judge the count before the drop.
          fill_d = fill_q;
          sum_d  = CntW'(sum_ext - LenW'(oldest));
          if (sum_ext > tgt_ext) begin
            verdict_d = msa_pkg::VERDICT_DIVIDED;
            if ({8'd0, spread_q[31:8]} >= factor_q) begin
              // Quotient would not fit in 32 bits (includes a zero factor).
              spread_d = '1;
              state_d  = S_DONE;
            end else begin
              work_d  = {8'd0, spread_q[31:8], spread_q[7:0], 24'd0};
              state_d = S_DIV;
            end
          end else if (sum_ext == tgt_ext) begin
            verdict_d = msa_pkg::VERDICT_UNCHANGED;
            state_d   = S_DONE;
          end else begin
            verdict_d = msa_pkg::VERDICT_MULTIPLIED;
            work_d    = '0;
            mplier_d  = factor_q;
            state_d   = S_MUL;
          end
        end else begin
          fill_d    = CntW'(n_ext);
          sum_d     = CntW'(sum_ext);
          verdict_d = msa_pkg::VERDICT_FILLING;
          state_d   = S_DONE;
        end
      end

      S_MUL: begin
        work_d   = {mul_sum, work_q[31:1]};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == msa_pkg::StepCntW'(msa_pkg::SerialSteps - 1)) begin
          // The full product is {mul_sum, work_q[31:1]}: drop the 24 fraction
          // bits and saturate when anything is left above bit 31.
          spread_d = (mul_sum[32:25] != '0) ? '1 : {mul_sum[24:0], work_q[31:25]};
          state_d  = S_DONE;
        end
      end

      S_DIV: begin
        work_d = {(div_ge ? div_diff[31:0] : div_trial[31:0]), work_q[30:0], div_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == msa_pkg::StepCntW'(msa_pkg::SerialSteps - 1)) begin
          spread_d = {work_q[30:0], div_ge};
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= msa_pkg::WindowLengthReset;
      target_q    <= msa_pkg::SuccessTargetReset;
      factor_q    <= msa_pkg::StepFactorReset;
      best_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      head_q      <= '0;
      spread_q    <= msa_pkg::SpreadReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      best_q      <= best_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      head_q      <= head_d;
      spread_q    <= spread_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (msa_pkg::cfg_index_e'(cfg_index_i))
          msa_pkg::CFG_WINDOW_LENGTH:  win_len_q <= cfg_data_i[6:0];
          msa_pkg::CFG_SUCCESS_TARGET: target_q  <= cfg_data_i[6:0];
          msa_pkg::CFG_STEP_FACTOR:    factor_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    imp_q     <= imp_d;
    verdict_q <= verdict_d;
    work_q    <= work_d;
    mplier_q  <= mplier_d;
    if (out_load) begin
      out_spread_q  <= spread_q;
      out_verdict_q <= verdict_q;
      out_imp_q     <= imp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign spread_o    = out_spread_q;
  assign verdict_o   = out_verdict_q;
  assign improved_o  = out_imp_q;

  // The window never holds more than one bit less than its depth between items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MAX_WINDOW - 1))
    else $error("window fill exceeds its depth");

  // The success count can never exceed the number of bits in the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= fill_q)
    else $error("success count exceeds window fill");

  // An input transfer always leads straight to the window decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOK))
    else $error("accepted item did not reach the decision step");

  // A finished result waits while the output register is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result left the unit while the output was stalled");

  // A result is loaded into the output register only from the finished state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == S_DONE))
    else $error("output became valid without a finished result");

endmodule

>>> tb/tb_mutation_spread_adapter.sv
// Self-checking testbench for mutation_spread_adapter: directed probes, then
// randomized generations under several register settings, scored by a model or
// by typed expectations. Depends on msa_pkg and the adapter RTL; reads no files.
module tb_mutation_spread_adapter;

  localparam int unsigned WindowCap = 64;
  localparam int unsigned IdlePct = 23;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned HoldAfter = 110;
  localparam int unsigned DrainCycles = 40;

  // One result transfer, in the order of the output ports.
  typedef struct packed {
    logic [31:0]       spread;
    msa_pkg::verdict_e verdict;
    logic              improved;
  } spread_result_t;

  // One line of the directed table: either a register write or a generation.
  // Rows marked typed carry a hand-written expectation instead of the model's.
  typedef struct {
    bit                  is_write;
    msa_pkg::cfg_index_e reg_idx;
    logic [31:0]         reg_data;
    logic signed [31:0]  fitness;
    bit                  typed;
    spread_result_t      want;
  } probe_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] best_fitness_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        spread_o;
  logic [1:0]         verdict_o;
  logic               improved_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = msa_pkg::CFG_WINDOW_LENGTH;
  logic [31:0]        cfg_data_i = '0;

  mutation_spread_adapter #(
    .MAX_WINDOW(WindowCap)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .best_fitness_i(best_fitness_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .spread_o      (spread_o),
    .verdict_o     (verdict_o),
    .improved_o    (improved_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Our own copy of the adapter's registers and state, as they stand after reset.
  logic [6:0]                 cfg_window = msa_pkg::WindowLengthReset;
  logic [6:0]                 cfg_target = msa_pkg::SuccessTargetReset;
  logic [31:0]                cfg_factor = msa_pkg::StepFactorReset;
  logic signed [31:0]         best_seen = '0;
  logic [WindowCap-1:0]       win_bits = '0;
  int unsigned                win_fill = 0;
  int unsigned                win_sum = 0;
  logic [31:0]                spread_q = msa_pkg::SpreadReset;

  // Results owed by the adapter, oldest first, plus run bookkeeping.
  spread_result_t             spread_due[$];
  int unsigned                mismatches = 0;
  int unsigned                outputs_seen = 0;
  bit                         no_idle = 1'b0;
  bit                         hold_done = 1'b0;

  // Register writes land in our copy exactly as in the block: the two
  // 7-bit registers keep only their low bits and index 3 is ignored.
  function automatic void apply_reg(input msa_pkg::cfg_index_e idx,
                                    input logic [31:0] data);
    case (idx)
      msa_pkg::CFG_WINDOW_LENGTH:  cfg_window = data[6:0];
      msa_pkg::CFG_SUCCESS_TARGET: cfg_target = data[6:0];
      msa_pkg::CFG_STEP_FACTOR:    cfg_factor = data;
      default: ;
    endcase
  endfunction

  // Advances our copy of the adapter by one generation and returns the
  // result the block should deliver for it.
  function automatic spread_result_t adapt_spread(input logic signed [31:0] fit);
    spread_result_t res;
    int unsigned    span;
    int unsigned    n;
    int unsigned    sum;
    logic           oldest;
    logic [63:0]    wide;
    span = cfg_window;
    if (span == 0) begin
      span = 1;
    end else if (span > WindowCap) begin
      span = WindowCap;
    end
    // An empty window always counts as a success and re-anchors the best.
    res.improved = (win_fill == 0) || (fit < best_seen);
    if (res.improved) begin
      best_seen = fit;
    end
    if (win_fill > WindowCap - 1) begin
      win_fill = WindowCap - 1;
    end
    // Bit 0 is the newest generation; bits at or above the fill are zero.
    win_bits = {win_bits[WindowCap-2:0], res.improved};
    n = win_fill + 1;
    sum = win_sum + res.improved;
    if (n >= span) begin
      // The count compared below still includes the bit being dropped.
      oldest = win_bits[n-1];
      win_bits[n-1] = 1'b0;
      n--;
      win_sum = sum - oldest;
      if (sum > cfg_target) begin
        if (cfg_factor == '0) begin
          spread_q = '1;
        end else begin
          wide = {8'd0, spread_q, 24'd0} / {32'd0, cfg_factor};
          spread_q = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
        end
        res.verdict = msa_pkg::VERDICT_DIVIDED;
      end else if (sum == cfg_target) begin
        res.verdict = msa_pkg::VERDICT_UNCHANGED;
      end else begin
        wide = ({32'd0, spread_q} * {32'd0, cfg_factor}) >> msa_pkg::FracBits;
        spread_q = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
        res.verdict = msa_pkg::VERDICT_MULTIPLIED;
      end
    end else begin
      win_sum = sum;
      res.verdict = msa_pkg::VERDICT_FILLING;
    end
    win_fill = n;
    res.spread = spread_q;
    return res;
  endfunction

  // A fitness strictly below the best so far, unless that would wrap.
  function automatic logic signed [31:0] fitness_below(input int unsigned max_step);
    longint cand;
    cand = longint'(best_seen) - longint'($urandom_range(max_step, 1));
    if (cand < -64'sd2147483648) begin
      cand = best_seen;
    end
    return cand[31:0];
  endfunction

  function automatic probe_row_t reg_row(input msa_pkg::cfg_index_e idx,
                                         input logic [31:0] data);
    probe_row_t row;
    row = '{is_write: 1'b1, reg_idx: idx, reg_data: data, fitness: '0, typed: 1'b0,
            want: '0};
    return row;
  endfunction

  function automatic probe_row_t item_row(input logic signed [31:0] fit);
    probe_row_t row;
    row = '{is_write: 1'b0, reg_idx: msa_pkg::CFG_WINDOW_LENGTH, reg_data: '0,
            fitness: fit, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic probe_row_t typed_row(input logic signed [31:0] fit,
                                           input logic [31:0] spread,
                                           input msa_pkg::verdict_e verdict);
    probe_row_t row;
    // Every typed row is a success: each of them runs with an empty window.
    row = '{is_write: 1'b0, reg_idx: msa_pkg::CFG_WINDOW_LENGTH, reg_data: '0,
            fitness: fit, typed: 1'b1,
            want: '{spread: spread, verdict: verdict, improved: 1'b1}};
    return row;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Offers one generation on the input channel, idling first at random.
  // The model is stepped at the transfer, since registers never change while
  // generations are in flight.
  task automatic send_fitness(input logic signed [31:0] fit, input bit use_typed,
                              input spread_result_t typed_want);
    spread_result_t predicted;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    best_fitness_i <= fit;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = adapt_spread(fit);
    spread_due.push_back(use_typed ? typed_want : predicted);
  endtask

  // Stops offering and waits until every owed result has come back. Each
  // generation yields exactly one result, so the block is idle afterwards.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (spread_due.size() != 0) @(negedge clk_i);
  endtask

  // One cycle with the write enable high, then low again.
  task automatic write_reg(input msa_pkg::cfg_index_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    apply_reg(idx, data);
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Once the spread is stuck at zero or saturated it cannot leave on its own.
  // A divide by a zero factor forces it to all ones, and a divide by a large
  // factor then brings it back to somewhere between 1.0 and 16.0.
  task automatic restore_spread();
    settle();
    write_reg(msa_pkg::CFG_WINDOW_LENGTH, 32'd1);
    write_reg(msa_pkg::CFG_SUCCESS_TARGET, 32'd0);
    write_reg(msa_pkg::CFG_STEP_FACTOR, 32'd0);
    send_fitness(fitness_below(4096), 1'b0, '0);
    settle();
    write_reg(msa_pkg::CFG_STEP_FACTOR, $urandom_range(32'hFFFF_FFFF, 32'h1000_0000));
    send_fitness(fitness_below(4096), 1'b0, '0);
  endtask

  // Result side: compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin : score_results
    spread_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      outputs_seen++;
      if (spread_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result spread %h verdict %0d", spread_o,
                                verdict_o));
      end else begin
        want = spread_due.pop_front();
        if (spread_o !== want.spread) begin
          note_mismatch($sformatf("spread %h, expected %h", spread_o, want.spread));
        end
        if (verdict_o !== want.verdict) begin
          note_mismatch($sformatf("verdict %0d, expected %s", verdict_o,
                                  want.verdict.name()));
        end
        if (improved_o !== want.improved) begin
          note_mismatch($sformatf("improved %b, expected %b", improved_o,
                                  want.improved));
        end
      end
    end
  end

  // Receiver: ready drops at random, except in the steady phase. Once, well
  // into the run, it refuses results for a long stretch while the sender
  // keeps offering, so the output register and the serial unit both fill and
  // the input channel has to stall.
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (!hold_done && outputs_seen >= HoldAfter) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Watchdog: too long without any transfer on either channel means a hang.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("mutation_spread_adapter verification failed");
    $finish;
  end

  initial begin : stimulus
    probe_row_t         probes[$];
    int unsigned        phase_windows[7];
    int unsigned        span;
    int unsigned        target;
    logic [31:0]        factor;
    logic signed [31:0] fit;
    longint             above;
    int unsigned        pick;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The first rows keep the window at one generation, so
    // it never fills past zero: every generation is a success and the
    // verdict follows from the target alone, which makes the expected
    // results easy to write down.
    probes.push_back(reg_row(msa_pkg::CFG_WINDOW_LENGTH, 32'd0));     // zero acts as one
    probes.push_back(typed_row(32'sh8000_0000, msa_pkg::SpreadReset,
                               msa_pkg::VERDICT_MULTIPLIED));
    probes.push_back(typed_row(32'sh7FFF_FFFF, msa_pkg::SpreadReset,
                               msa_pkg::VERDICT_MULTIPLIED));
    probes.push_back(typed_row(32'sh0000_0000, msa_pkg::SpreadReset,
                               msa_pkg::VERDICT_MULTIPLIED));
    // Upper data bits of a 7-bit register are dropped: the target becomes 0.
    probes.push_back(reg_row(msa_pkg::CFG_SUCCESS_TARGET, 32'hFFFF_FF80));
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'd0));
    // A zero factor saturates the divide.
    probes.push_back(typed_row(32'sh1234_5678, 32'hFFFF_FFFF, msa_pkg::VERDICT_DIVIDED));
    // A target above the window forces growth; 4.0 saturates the multiply.
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'h0400_0000));
    probes.push_back(reg_row(msa_pkg::CFG_SUCCESS_TARGET, 32'd127));
    probes.push_back(typed_row(-32'sd1, 32'hFFFF_FFFF, msa_pkg::VERDICT_MULTIPLIED));
    // A zero factor on the multiply clears the spread.
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'd0));
    probes.push_back(typed_row(32'sd1, 32'd0, msa_pkg::VERDICT_MULTIPLIED));
    // A zero spread stays zero under an ordinary divide.
    probes.push_back(reg_row(msa_pkg::CFG_SUCCESS_TARGET, 32'd0));
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'd1));
    probes.push_back(typed_row(32'sd2, 32'd0, msa_pkg::VERDICT_DIVIDED));
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'd0));
    probes.push_back(typed_row(32'sd3, 32'hFFFF_FFFF, msa_pkg::VERDICT_DIVIDED));
    // All ones divided by the largest factor is exactly 1.0.
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'hFFFF_FFFF));
    probes.push_back(typed_row(32'sd4, 32'h0100_0000, msa_pkg::VERDICT_DIVIDED));
    // Dividing by the smallest factor overflows the quotient.
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'd1));
    probes.push_back(typed_row(32'sd5, 32'hFFFF_FFFF, msa_pkg::VERDICT_DIVIDED));
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'hFFFF_FFFF));
    probes.push_back(typed_row(32'sd6, 32'h0100_0000, msa_pkg::VERDICT_DIVIDED));
    // Count equal to the target leaves the spread alone.
    probes.push_back(reg_row(msa_pkg::CFG_SUCCESS_TARGET, 32'd1));
    probes.push_back(typed_row(32'sd7, 32'h0100_0000, msa_pkg::VERDICT_UNCHANGED));
    probes.push_back(reg_row(msa_pkg::CFG_UNUSED, 32'hDEAD_BEEF));    // must be ignored
    // A real window of four with a 1.5 factor, then shrunk to two mid-run.
    probes.push_back(reg_row(msa_pkg::CFG_WINDOW_LENGTH, 32'hA5A5_A584));
    probes.push_back(reg_row(msa_pkg::CFG_SUCCESS_TARGET, 32'd2));
    probes.push_back(reg_row(msa_pkg::CFG_STEP_FACTOR, 32'h0180_0000));
    probes.push_back(item_row(32'sd100));
    probes.push_back(item_row(32'sd200));
    probes.push_back(item_row(32'sd50));
    probes.push_back(item_row(32'sd50));                       // a tie is no success
    probes.push_back(item_row(-32'sd20));
    probes.push_back(item_row(-32'sd1000));
    probes.push_back(item_row(32'sd0));
    probes.push_back(reg_row(msa_pkg::CFG_WINDOW_LENGTH, 32'd2));
    probes.push_back(item_row(-32'sd2000));
    probes.push_back(item_row(32'sd5));
    probes.push_back(item_row(-32'sd3000));

    foreach (probes[i]) begin
      if (probes[i].is_write) begin
        settle();
        write_reg(probes[i].reg_idx, probes[i].reg_data);
      end else begin
        send_fitness(probes[i].fitness, probes[i].typed, probes[i].want);
      end
    end

    // Random part. Each phase picks a window, a target and a factor, then
    // runs a stretch of generations. Most fitness values move a little below
    // or above the best so far, so successes stay common without driving the
    // best toward the negative limit; the rest are unrelated positive values.
    // The fill never shrinks, so a smaller window keeps an earlier, larger fill.
    phase_windows = '{5, 9, 3, 64, 100, 127, 7};
    for (int p = 0; p < 7; p++) begin
      settle();
      if (spread_q < 32'h100 || spread_q == '1) begin
        restore_spread();
      end
      settle();
      // The second phase runs with neither side idling.
      no_idle = (p == 1);
      span = (phase_windows[p] > WindowCap) ? WindowCap : phase_windows[p];
      if (p == 2) begin
        target = 127;
      end else if (p == 3) begin
        target = 64;
      end else begin
        target = $urandom_range(span / 3 + 1, 0);
      end
      if (p == 4) begin
        factor = $urandom;
      end else begin
        factor = $urandom_range(32'h0130_0000, 32'h00D0_0000);
      end
      write_reg(msa_pkg::CFG_WINDOW_LENGTH, ($urandom & ~32'h7F) | phase_windows[p]);
      write_reg(msa_pkg::CFG_SUCCESS_TARGET, ($urandom & ~32'h7F) | target);
      write_reg(msa_pkg::CFG_STEP_FACTOR, factor);
      repeat (55 + $urandom_range(10)) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          fit = fitness_below(65536);
        end else if (pick < 85) begin
          above = longint'(best_seen) + longint'($urandom_range(65536, 0));
          fit = (above > 64'sd2147483647) ? 32'sh7FFF_FFFF : above[31:0];
        end else begin
          fit = $urandom & 32'h7FFF_FFFF;
        end
        send_fitness(fit, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // Drain, then leave room for any stray result to show up.
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mutation_spread_adapter verification clean");
    end else begin
      $display("mutation_spread_adapter verification failed");
    end
    $finish;
  end

endmodule
